// ===== rtl/core/nddi_pkg.sv =====
package nddi_pkg;

    localparam int MAX_NODES = 8;
    localparam int FRAC_BITS = 40;
    localparam int DATA_W    = 64;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int KIND_W    = 2;
    localparam int IDX_W     = 3;
    localparam int STATUS_W  = 2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [KIND_W-1:0] KIND_COEF  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUPP  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DZ  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

    localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] node_abscissa;
        logic signed [DATA_W-1:0] node_value;
        logic                     last_node;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]        result_kind;
        logic [IDX_W-1:0]         coef_index;
        logic signed [DATA_W-1:0] result_data;
        logic [STATUS_W-1:0]      status;
        logic                     last_result;
    } t_out_item;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic sat;
        logic dz;
    } t_alu_rsp;

endpackage

// ===== rtl/core/nddi_ram.sv =====
module nddi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/nddi_alu.sv =====
module nddi_alu (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nddi_pkg::t_alu_req       i_req,
    input  logic [nddi_pkg::DATA_W-1:0] i_a,
    input  logic [nddi_pkg::DATA_W-1:0] i_b,
    output nddi_pkg::t_alu_rsp       o_rsp,
    output logic [nddi_pkg::DATA_W-1:0] o_result
);
    import nddi_pkg::*;

    localparam int HALF      = DATA_W / 2;
    localparam int DIV_STEPS = 2 * DATA_W;
    localparam int MUL_STEPS = 5;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // Returns {saturated, value} for a sign and an unsigned magnitude.
    function automatic logic [DATA_W:0] pack(input logic neg, input logic [DATA_W-1:0] mag);
        logic [DATA_W-1:0] m;
        logic              s;
        begin
            m = mag;
            s = 1'b0;
            if (neg && mag > NEG_MIN) begin
                m = NEG_MIN;
                s = 1'b1;
            end else if (!neg && mag > POS_MAX) begin
                m = POS_MAX;
                s = 1'b1;
            end
            pack = {s, neg ? (DATA_W'(0) - m) : m};
        end
    endfunction

    logic                r_busy;
    logic [1:0]          r_op;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_neg;
    logic [DATA_W-1:0]   r_ma;
    logic [DATA_W-1:0]   r_mb;
    logic [DATA_W-1:0]   r_prod;
    logic [2*DATA_W-1:0] r_acc;
    logic [2*DATA_W-1:0] r_dvd;
    logic [DATA_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_q;
    logic                r_qovf;
    logic                r_done;
    logic                r_sat;
    logic                r_dz;
    logic [DATA_W-1:0]   r_result;

    logic [DATA_W:0]     add_sum;
    logic [DATA_W:0]     sub_dif;
    logic [DATA_W-1:0]   mag_a;
    logic [DATA_W-1:0]   mag_b;
    logic [HALF-1:0]     mul_x;
    logic [HALF-1:0]     mul_y;
    logic [2*DATA_W-1:0] prod_sh;
    logic [DATA_W:0]     rem_sh;
    logic                q_bit;
    logic [DATA_W:0]     mul_pk;
    logic [DATA_W:0]     div_pk;
    logic [STEP_W-1:0]   acc_k;

    always_comb begin
        add_sum = {i_a[DATA_W-1], i_a} + {i_b[DATA_W-1], i_b};
        sub_dif = {i_a[DATA_W-1], i_a} - {i_b[DATA_W-1], i_b};
        mag_a   = i_a[DATA_W-1] ? (DATA_W'(0) - i_a) : i_a;
        mag_b   = i_b[DATA_W-1] ? (DATA_W'(0) - i_b) : i_b;
        mul_x   = r_cnt[1] ? r_ma[DATA_W-1:HALF] : r_ma[HALF-1:0];
        mul_y   = r_cnt[0] ? r_mb[DATA_W-1:HALF] : r_mb[HALF-1:0];
        acc_k   = r_cnt - STEP_W'(1);
        case (acc_k[1:0])
            2'd0:    prod_sh = {{DATA_W{1'b0}}, r_prod};
            2'd3:    prod_sh = {r_prod, {DATA_W{1'b0}}};
            default: prod_sh = {{HALF{1'b0}}, r_prod, {HALF{1'b0}}};
        endcase
        rem_sh  = {r_rem, r_dvd[2*DATA_W-1]};
        q_bit   = rem_sh >= {1'b0, r_mb};
        mul_pk  = pack(r_neg, r_acc[DATA_W+FRAC_BITS-1:FRAC_BITS]);
        div_pk  = pack(r_neg, r_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_op  <= i_req.op;
                r_cnt <= '0;
                r_neg <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
                r_ma  <= mag_a;
                r_mb  <= mag_b;
                case (i_req.op)
                    OP_ADD: begin
                        r_done   <= 1'b1;
                        r_dz     <= 1'b0;
                        r_sat    <= add_sum[DATA_W] != add_sum[DATA_W-1];
                        r_result <= (add_sum[DATA_W] != add_sum[DATA_W-1])
                                    ? (add_sum[DATA_W] ? NEG_MIN : POS_MAX)
                                    : add_sum[DATA_W-1:0];
                    end
                    OP_SUB: begin
                        r_done   <= 1'b1;
                        r_dz     <= 1'b0;
                        r_sat    <= sub_dif[DATA_W] != sub_dif[DATA_W-1];
                        r_result <= (sub_dif[DATA_W] != sub_dif[DATA_W-1])
                                    ? (sub_dif[DATA_W] ? NEG_MIN : POS_MAX)
                                    : sub_dif[DATA_W-1:0];
                    end
                    OP_MUL: begin
                        r_done <= 1'b0;
                        r_sat  <= 1'b0;
                        r_dz   <= 1'b0;
                        r_busy <= 1'b1;
                        r_acc  <= '0;
                    end
                    default: begin
                        if (i_b == '0) begin
                            // Equal nodes: flag and return zero or the signed limit.
                            r_done   <= 1'b1;
                            r_sat    <= 1'b0;
                            r_dz     <= 1'b1;
                            r_result <= (i_a == '0) ? '0
                                        : (i_a[DATA_W-1] ? NEG_MIN : POS_MAX);
                        end else begin
                            r_done <= 1'b0;
                            r_sat  <= 1'b0;
                            r_dz   <= 1'b0;
                            r_busy <= 1'b1;
                            r_dvd  <= {{(DATA_W-FRAC_BITS){1'b0}}, mag_a, {FRAC_BITS{1'b0}}};
                            r_rem  <= '0;
                            r_q    <= '0;
                            r_qovf <= 1'b0;
                        end
                    end
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_op == OP_MUL) begin
                    r_prod <= mul_x * mul_y;
                    if (r_cnt != '0 && r_cnt < STEP_W'(MUL_STEPS)) begin
                        r_acc <= r_acc + prod_sh;
                    end
                    if (r_cnt == STEP_W'(MUL_STEPS)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        if (|r_acc[2*DATA_W-1:DATA_W+FRAC_BITS]) begin
                            r_sat    <= 1'b1;
                            r_result <= r_neg ? NEG_MIN : POS_MAX;
                        end else begin
                            r_sat    <= mul_pk[DATA_W];
                            r_result <= mul_pk[DATA_W-1:0];
                        end
                    end else begin
                        r_done <= 1'b0;
                    end
                end else begin
                    if (r_cnt == STEP_W'(DIV_STEPS)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        if (r_qovf) begin
                            r_sat    <= 1'b1;
                            r_result <= r_neg ? NEG_MIN : POS_MAX;
                        end else begin
                            r_sat    <= div_pk[DATA_W];
                            r_result <= div_pk[DATA_W-1:0];
                        end
                    end else begin
                        // One quotient bit per cycle, restoring division.
                        r_done <= 1'b0;
                        r_rem  <= q_bit ? DATA_W'(rem_sh - {1'b0, r_mb}) : rem_sh[DATA_W-1:0];
                        r_q    <= {r_q[DATA_W-2:0], q_bit};
                        r_qovf <= r_qovf | r_q[DATA_W-1];
                        r_dvd  <= {r_dvd[2*DATA_W-2:0], 1'b0};
                    end
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.dz   = r_dz;
    assign o_result   = r_result;

endmodule

// ===== rtl/core/newton_divided_difference_interp.sv =====
// Loading: one node item per cycle while the block is idle.
// Closing a set of n nodes: n(n-1)/2 table steps (shorter for equal nodes, whose division is skipped),
// one quotient bit per cycle in the shared unit, then n evaluation steps.
// Results: each coefficient, then the value and the product, queued in turn as the output slot is taken.
// The block takes no input item from the last node until its last result is queued.
// Reset is synchronous, active low; it clears control state and sets eval_point to 0.
module newton_divided_difference_interp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  nddi_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output nddi_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_we,
    input  logic [nddi_pkg::DATA_W-1:0] i_cfg_wdata
);
    import nddi_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RD1   = 5'd1;
    localparam logic [4:0] S_RD2   = 5'd2;
    localparam logic [4:0] S_RD3   = 5'd3;
    localparam logic [4:0] S_NUM   = 5'd4;
    localparam logic [4:0] S_DEN   = 5'd5;
    localparam logic [4:0] S_WR    = 5'd6;
    localparam logic [4:0] S_ERD   = 5'd7;
    localparam logic [4:0] S_ECAP  = 5'd8;
    localparam logic [4:0] S_EADD  = 5'd9;
    localparam logic [4:0] S_ESUB  = 5'd10;
    localparam logic [4:0] S_EHM   = 5'd11;
    localparam logic [4:0] S_ENEXT = 5'd12;
    localparam logic [4:0] S_ORD   = 5'd13;
    localparam logic [4:0] S_OLD   = 5'd14;
    localparam logic [4:0] S_OY    = 5'd15;
    localparam logic [4:0] S_OM    = 5'd16;
    localparam logic [4:0] S_GO    = 5'd17;
    localparam logic [4:0] S_WAIT  = 5'd18;

    logic [4:0]         r_state;
    logic [4:0]         r_ret;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_j;
    logic [NODE_AW-1:0] r_i;
    logic [DATA_W-1:0]  r_eval;
    logic [DATA_W-1:0]  r_a;
    logic [DATA_W-1:0]  r_xa;
    logic [DATA_W-1:0]  r_xb;
    logic [DATA_W-1:0]  r_num;
    logic [DATA_W-1:0]  r_y;
    logic [DATA_W-1:0]  r_h;
    logic [DATA_W-1:0]  r_mag;
    logic [DATA_W-1:0]  r_res;
    logic [1:0]         r_op;
    logic [DATA_W-1:0]  r_opa;
    logic [DATA_W-1:0]  r_opb;
    logic               r_sat;
    logic               r_dz;
    logic               r_ovalid;
    t_out_item          r_out;

    logic               in_acc;
    logic               slot_free;
    logic               out_load;
    logic [CNT_W-1:0]   n_count;
    logic [STATUS_W-1:0] set_status;
    logic [NODE_AW-1:0] nm1;

    logic               d_we;
    logic [NODE_AW-1:0] d_waddr;
    logic [DATA_W-1:0]  d_wdata;
    logic               d_re;
    logic [NODE_AW-1:0] d_raddr;
    logic [DATA_W-1:0]  d_q;
    logic               x_re;
    logic [NODE_AW-1:0] x_raddr;
    logic [DATA_W-1:0]  x_q;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;
    logic [DATA_W-1:0]  alu_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_ovalid || i_out_ready;
    assign out_load   = slot_free && (r_state == S_OLD || r_state == S_OY || r_state == S_OM);
    assign n_count    = (r_count < CNT_W'(MAX_NODES)) ? r_count + CNT_W'(1) : r_count;
    assign set_status = r_dz ? ST_DZ : (r_sat ? ST_SAT : ST_OK);
    assign nm1        = NODE_AW'(r_n - CNT_W'(1));

    always_comb begin
        d_we    = 1'b0;
        d_waddr = r_count[NODE_AW-1:0];
        d_wdata = i_in_item.node_value;
        d_re    = 1'b0;
        d_raddr = r_j[NODE_AW-1:0];
        x_re    = 1'b0;
        x_raddr = r_j[NODE_AW-1:0];
        case (r_state)
            S_IDLE: begin
                d_we = in_acc && (r_count < CNT_W'(MAX_NODES));
            end
            S_RD1: begin
                d_re    = 1'b1;
                x_re    = 1'b1;
                d_raddr = r_i;
                x_raddr = r_i;
            end
            S_RD2: begin
                d_re    = 1'b1;
                x_re    = 1'b1;
                d_raddr = r_i - NODE_AW'(1);
                x_raddr = r_i - r_j[NODE_AW-1:0];
            end
            S_WR: begin
                d_we    = 1'b1;
                d_waddr = r_i;
                d_wdata = r_res;
            end
            S_ERD: begin
                d_re = 1'b1;
                x_re = 1'b1;
            end
            S_ORD: begin
                d_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    nddi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (d_we && r_state == S_IDLE),
        .i_waddr (r_count[NODE_AW-1:0]),
        .i_wdata (i_in_item.node_abscissa),
        .i_re    (x_re),
        .i_raddr (x_raddr),
        .o_rdata (x_q)
    );

    nddi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_diff_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_q)
    );

    assign alu_req.start = (r_state == S_GO);
    assign alu_req.op    = r_op;

    nddi_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_opa),
        .i_b      (r_opb),
        .o_rsp    (alu_rsp),
        .o_result (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_eval   <= '0;
            r_ovalid <= 1'b0;
            r_sat    <= 1'b0;
            r_dz     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eval <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (alu_rsp.done) begin
                r_sat <= r_sat | alu_rsp.sat;
                r_dz  <= r_dz | alu_rsp.dz;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_count <= n_count;
                        if (i_in_item.last_node) begin
                            r_n   <= n_count;
                            r_sat <= 1'b0;
                            r_dz  <= 1'b0;
                            r_y   <= '0;
                            r_h   <= DATA_W'(1) << FRAC_BITS;
                            if (n_count > CNT_W'(1)) begin
                                r_j     <= CNT_W'(1);
                                r_i     <= NODE_AW'(n_count - CNT_W'(1));
                                r_state <= S_RD1;
                            end else begin
                                r_j     <= '0;
                                r_state <= S_ERD;
                            end
                        end
                    end
                end
                S_RD1: r_state <= S_RD2;
                S_RD2: begin
                    r_a     <= d_q;
                    r_xa    <= x_q;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_xb    <= x_q;
                    r_op    <= OP_SUB;
                    r_opa   <= r_a;
                    r_opb   <= d_q;
                    r_ret   <= S_NUM;
                    r_state <= S_GO;
                end
                S_NUM: begin
                    r_num   <= r_res;
                    r_op    <= OP_SUB;
                    r_opa   <= r_xa;
                    r_opb   <= r_xb;
                    r_ret   <= S_DEN;
                    r_state <= S_GO;
                end
                S_DEN: begin
                    r_op    <= OP_DIV;
                    r_opa   <= r_num;
                    r_opb   <= r_res;
                    r_ret   <= S_WR;
                    r_state <= S_GO;
                end
                S_WR: begin
                    // Walk each column from the top entry down to the column index.
                    if ({1'b0, r_i} == {1'b0, r_j[NODE_AW-1:0]}) begin
                        if (r_j + CNT_W'(1) == r_n) begin
                            r_j     <= '0;
                            r_state <= S_ERD;
                        end else begin
                            r_j     <= r_j + CNT_W'(1);
                            r_i     <= nm1;
                            r_state <= S_RD1;
                        end
                    end else begin
                        r_i     <= r_i - NODE_AW'(1);
                        r_state <= S_RD1;
                    end
                end
                S_ERD: r_state <= S_ECAP;
                S_ECAP: begin
                    r_xa    <= x_q;
                    r_op    <= OP_MUL;
                    r_opa   <= d_q;
                    r_opb   <= r_h;
                    r_ret   <= S_EADD;
                    r_state <= S_GO;
                end
                S_EADD: begin
                    r_op    <= OP_ADD;
                    r_opa   <= r_y;
                    r_opb   <= r_res;
                    r_ret   <= S_ESUB;
                    r_state <= S_GO;
                end
                S_ESUB: begin
                    r_y     <= r_res;
                    r_op    <= OP_SUB;
                    r_opa   <= r_eval;
                    r_opb   <= r_xa;
                    r_ret   <= S_EHM;
                    r_state <= S_GO;
                end
                S_EHM: begin
                    r_op    <= OP_MUL;
                    r_opa   <= r_h;
                    r_opb   <= r_res;
                    r_ret   <= S_ENEXT;
                    r_state <= S_GO;
                end
                S_ENEXT: begin
                    r_h <= r_res;
                    if (r_j + CNT_W'(1) == r_n) begin
                        // The magnitude of the most negative word saturates.
                        if (r_res == NEG_MIN) begin
                            r_mag <= POS_MAX;
                            r_sat <= 1'b1;
                        end else begin
                            r_mag <= r_res[DATA_W-1] ? (DATA_W'(0) - r_res) : r_res;
                        end
                        r_j     <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_j     <= r_j + CNT_W'(1);
                        r_state <= S_ERD;
                    end
                end
                S_ORD: r_state <= S_OLD;
                S_OLD: begin
                    if (slot_free) begin
                        r_out.result_kind <= KIND_COEF;
                        r_out.coef_index  <= IDX_W'(r_j);
                        r_out.result_data <= d_q;
                        r_out.status      <= set_status;
                        r_out.last_result <= 1'b0;
                        if (r_j + CNT_W'(1) == r_n) begin
                            r_state <= S_OY;
                        end else begin
                            r_j     <= r_j + CNT_W'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                S_OY: begin
                    if (slot_free) begin
                        r_out.result_kind <= KIND_VALUE;
                        r_out.coef_index  <= '0;
                        r_out.result_data <= r_y;
                        r_out.status      <= set_status;
                        r_out.last_result <= 1'b0;
                        r_state           <= S_OM;
                    end
                end
                S_OM: begin
                    if (slot_free) begin
                        r_out.result_kind <= KIND_SUPP;
                        r_out.coef_index  <= '0;
                        r_out.result_data <= r_mag;
                        r_out.status      <= set_status;
                        r_out.last_result <= 1'b1;
                        r_count           <= '0;
                        r_state           <= S_IDLE;
                    end
                end
                S_GO: r_state <= S_WAIT;
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        r_res   <= alu_res;
                        r_state <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> r_state == S_WAIT)
        else $error("arithmetic result arrived outside the wait state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_NODES))
        else $error("node count beyond capacity");

    a_coef_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.result_kind == KIND_COEF && r_state != S_IDLE
        |-> CNT_W'(o_out_item.coef_index) < r_n)
        else $error("coefficient index beyond node count");

    a_last_ends_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && o_out_item.last_result |-> r_state == S_IDLE)
        else $error("last result queued while the set is still open");

endmodule

// ===== verif/newton_divided_difference_interp_test.sv =====
`timescale 1ns / 100ps

module newton_divided_difference_interp_test;
    import nddi_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_item;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_item;
    logic              i_cfg_we;
    logic [DATA_W-1:0] i_cfg_wdata;

    newton_divided_difference_interp uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_in_item  pending_nodes[$];
    t_out_item expected_results[$];

    // Shadow copy of the interpolator state.
    logic [DATA_W-1:0] abscissa_mem[MAX_NODES];
    logic [DATA_W-1:0] diff_mem[MAX_NODES];
    int                stored_nodes;
    logic [DATA_W-1:0] eval_pt;
    logic              dz_seen;
    logic              sat_seen;

    int   mismatch_count;
    int   idle_cycles;
    int   items_queued;
    logic in_taken;
    logic out_taken;
    logic no_idle;
    logic hold_go;
    logic hold_done;
    int   send_gap;
    int   recv_stall;

    always #5 i_clk = ~i_clk;

    function automatic logic [DATA_W-1:0] sat_to(logic neg);
        sat_seen = 1'b1;
        return neg ? NEG_MIN : POS_MAX;
    endfunction

    function automatic logic [DATA_W-1:0] fit_sign(logic neg, logic [DATA_W-1:0] mag);
        logic [DATA_W-1:0] lim;
        lim = neg ? NEG_MIN : POS_MAX;
        if (mag > lim) begin
            sat_seen = 1'b1;
            mag = lim;
        end
        return neg ? -mag : mag;
    endfunction

    function automatic logic [DATA_W-1:0] q_add(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        r = a + b;
        if (a[DATA_W-1] == b[DATA_W-1] && r[DATA_W-1] != a[DATA_W-1])
            return sat_to(a[DATA_W-1]);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] q_sub(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        r = a - b;
        if (a[DATA_W-1] != b[DATA_W-1] && r[DATA_W-1] != a[DATA_W-1])
            return sat_to(a[DATA_W-1]);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] q_mul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        logic              neg;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [127:0]      p;
        neg = a[DATA_W-1] ^ b[DATA_W-1];
        ma  = a[DATA_W-1] ? -a : a;
        mb  = b[DATA_W-1] ? -b : b;
        p   = {64'd0, ma} * {64'd0, mb};
        if (p[127:DATA_W+FRAC_BITS] != 0)
            return sat_to(neg);
        return fit_sign(neg, p[DATA_W+FRAC_BITS-1:FRAC_BITS]);
    endfunction

    function automatic logic [DATA_W-1:0] q_div(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        logic              neg;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [127:0]      q;
        if (b == 0) begin
            dz_seen = 1'b1;
            if (a == 0)
                return '0;
            return a[DATA_W-1] ? NEG_MIN : POS_MAX;
        end
        neg = a[DATA_W-1] ^ b[DATA_W-1];
        ma  = a[DATA_W-1] ? -a : a;
        mb  = b[DATA_W-1] ? -b : b;
        q   = ({64'd0, ma} << FRAC_BITS) / {64'd0, mb};
        if (q[127:DATA_W] != 0)
            return sat_to(neg);
        return fit_sign(neg, q[DATA_W-1:0]);
    endfunction

    // Stores one node; a closing node produces the coefficients, the value and the
    // support product of the whole set.
    task automatic predict_node(t_in_item it);
        logic [DATA_W-1:0]   acc;
        logic [DATA_W-1:0]   basis;
        logic [DATA_W-1:0]   mag;
        logic [STATUS_W-1:0] st;
        t_out_item           r;
        int                  n;
        if (stored_nodes < MAX_NODES) begin
            abscissa_mem[stored_nodes] = it.node_abscissa;
            diff_mem[stored_nodes]     = it.node_value;
            stored_nodes++;
        end
        if (!it.last_node)
            return;
        n        = stored_nodes;
        dz_seen  = 1'b0;
        sat_seen = 1'b0;
        for (int j = 1; j < n; j++)
            for (int i = n - 1; i >= j; i--)
                diff_mem[i] = q_div(q_sub(diff_mem[i], diff_mem[i-1]),
                                    q_sub(abscissa_mem[i], abscissa_mem[i-j]));
        acc   = '0;
        basis = 64'd1 << FRAC_BITS;
        for (int j = 0; j < n; j++) begin
            acc   = q_add(acc, q_mul(diff_mem[j], basis));
            basis = q_mul(basis, q_sub(eval_pt, abscissa_mem[j]));
        end
        mag = fit_sign(1'b0, basis[DATA_W-1] ? -basis : basis);
        st  = dz_seen ? ST_DZ : (sat_seen ? ST_SAT : ST_OK);
        for (int j = 0; j < n + 2; j++) begin
            r.result_kind = (j < n) ? KIND_COEF : ((j == n) ? KIND_VALUE : KIND_SUPP);
            r.coef_index  = (j < n) ? IDX_W'(j) : '0;
            r.result_data = (j < n) ? diff_mem[j] : ((j == n) ? acc : mag);
            r.status      = st;
            r.last_result = (j == n + 1);
            expected_results.push_back(r);
        end
        stored_nodes = 0;
    endtask

    // Prediction and result checking, both on the rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken  <= i_in_valid && o_in_ready;
        out_taken <= o_out_valid && i_out_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            predict_node(i_in_item);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: kind %0d data %h",
                       o_out_item.result_kind, o_out_item.result_data);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.result_kind !== want.result_kind) begin
                    $error("result_kind expected %0d actual %0d",
                           want.result_kind, o_out_item.result_kind);
                    mismatch_count++;
                end
                if (o_out_item.coef_index !== want.coef_index) begin
                    $error("coef_index expected %0d actual %0d",
                           want.coef_index, o_out_item.coef_index);
                    mismatch_count++;
                end
                if (o_out_item.result_data !== want.result_data) begin
                    $error("result_data expected %h actual %h",
                           want.result_data, o_out_item.result_data);
                    mismatch_count++;
                end
                if (o_out_item.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_out_item.status);
                    mismatch_count++;
                end
                if (o_out_item.last_result !== want.last_result) begin
                    $error("last_result expected %0d actual %0d",
                           want.last_result, o_out_item.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Node sender: waits a random number of cycles before each item.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_nodes.size() > 0) begin
                i_in_item  <= pending_nodes.pop_front();
                i_in_valid <= 1'b1;
                send_gap   <= no_idle ? 0 : $urandom_range(0, 8);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls a random number of cycles after each item, and once
    // for a long stretch on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_stall  <= 0;
            hold_done   <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done   <= 1'b1;
            recv_stall  <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall  <= recv_stall - 1;
            i_out_ready <= 1'b0;
        end else if (out_taken && !no_idle) begin
            recv_stall  <= $urandom_range(0, 8);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [DATA_W-1:0] pick_q();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return POS_MAX;
            2: return NEG_MIN;
            3: return {$urandom, $urandom} >> $urandom_range(0, 63);
            default: return 64'(signed'(int'($urandom_range(0, 1 << 20)) - (1 << 19))) << 30;
        endcase
    endfunction

    task automatic add_node(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic closing);
        t_in_item it;
        it.node_abscissa = x;
        it.node_value    = y;
        it.last_node     = closing;
        pending_nodes.push_back(it);
        items_queued++;
    endtask

    task automatic add_random_set();
        logic [DATA_W-1:0] xs[$];
        logic [DATA_W-1:0] x;
        int                n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            x = (k > 0 && $urandom_range(0, 11) == 0) ? xs[$urandom_range(0, k - 1)] : pick_q();
            xs.push_back(x);
            add_node(x, pick_q(), k == n - 1);
        end
    endtask

    task automatic drain();
        while (pending_nodes.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_eval_point(logic [DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        eval_pt = v;
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_out_ready    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        stored_nodes   = 0;
        eval_pt        = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        items_queued   = 0;
        in_taken       = 1'b0;
        out_taken      = 1'b0;
        no_idle        = 1'b0;
        hold_go        = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A single node, then equal nodes with and without a zero numerator.
        add_node('0, POS_MAX, 1'b1);
        add_node(64'd1 << FRAC_BITS, 64'd2 << FRAC_BITS, 1'b0);
        add_node(64'd1 << FRAC_BITS, 64'd3 << FRAC_BITS, 1'b1);
        add_node(64'd5 << FRAC_BITS, 64'd7, 1'b0);
        add_node(64'd5 << FRAC_BITS, 64'd7, 1'b1);
        // Extreme nodes and values force saturation.
        add_node(NEG_MIN, POS_MAX, 1'b0);
        add_node(POS_MAX, NEG_MIN, 1'b0);
        add_node('0, '0, 1'b1);
        // More nodes than the store holds; the extra ones are dropped.
        for (int k = 0; k < 10; k++)
            add_node(64'(k) << FRAC_BITS, 64'(k * k) << (FRAC_BITS - 2), k == 9);
        drain();

        // The support product reaches the most negative number.
        write_eval_point(NEG_MIN);
        add_node('0, 64'd1 << FRAC_BITS, 1'b1);
        for (int k = 0; k < 4; k++)
            add_node(64'(k + 1) << (FRAC_BITS + 1), {$urandom, $urandom}, k == 3);
        drain();
        write_eval_point(POS_MAX);
        add_random_set();
        add_random_set();
        drain();

        for (int phase = 0; items_queued < 450; phase++) begin
            case (phase % 4)
                0: write_eval_point('0);
                1: write_eval_point(pick_q());
                2: write_eval_point({$urandom, $urandom});
                default: write_eval_point(64'(signed'(int'($urandom_range(0, 64)) - 32))
                                          << (FRAC_BITS - 1));
            endcase
            no_idle = (phase % 5 == 2);
            if (phase == 3)
                hold_go = 1'b1;
            for (int s = 0; s < 8; s++)
                add_random_set();
            drain();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
